// File: sv/pgb_pkg.sv
// Shared types, codes and reset values for the proximity gesture button.
package pgb_pkg;

    // Press machine states
    typedef enum logic [3:0] {
        PS_REL        = 4'd0,
        PS_REL_SHORT  = 4'd1,
        PS_REL_LONG   = 4'd2,
        PS_SHORT      = 4'd3,
        PS_SHORT_LONG = 4'd4,
        PS_SHORT_REL  = 4'd5,
        PS_LONG       = 4'd6,
        PS_LONG_SHORT = 4'd7,
        PS_LONG_REL   = 4'd8
    } press_state_t;

    typedef enum logic [1:0] {
        G_NONE  = 2'd0,
        G_SHORT = 2'd1,
        G_LONG  = 2'd2
    } gesture_kind_t;

    typedef struct packed {
        logic [11:0] short_limit;
        logic [11:0] long_limit;
        logic [9:0]  hysteresis_step;
        logic [7:0]  idle_threshold;
        logic [11:0] range_limit;
    } cfg_t;

    // Register map, word index into paddr[4:2]
    localparam int          ADDR_W              = 5;
    localparam int          APB_DATA_W          = 32;
    localparam logic [2:0]  REG_SHORT_LIMIT     = 3'd0;
    localparam logic [2:0]  REG_LONG_LIMIT      = 3'd1;
    localparam logic [2:0]  REG_HYSTERESIS_STEP = 3'd2;
    localparam logic [2:0]  REG_IDLE_THRESHOLD  = 3'd3;
    localparam logic [2:0]  REG_RANGE_LIMIT     = 3'd4;

    localparam logic [11:0] SHORT_LIMIT_RST     = 12'd96;
    localparam logic [11:0] LONG_LIMIT_RST      = 12'd320;
    localparam logic [9:0]  HYSTERESIS_STEP_RST = 10'd16;
    localparam logic [7:0]  IDLE_THRESHOLD_RST  = 8'd5;
    localparam logic [11:0] RANGE_LIMIT_RST     = 12'd640;

    localparam int          DEF_WINDOW_DEPTH    = 10;
    localparam int          DEF_DISTANCE_BITS   = 12;
    localparam int          HIST_DEPTH          = 5;
    localparam int          MEAN_W              = 12;
    localparam int          M_DATA_W            = 24;
    localparam logic [7:0]  IDLE_MAX            = 8'hFF;

    // Width of the running window sum
    function automatic int sum_width(input int depth, input int bits);
        return $clog2(depth * ((1 << bits) - 1) + 1);
    endfunction

endpackage

// File: sv/pgb_window.sv
// Sample qualification, averaging window and running sum.
module pgb_window #(
    parameter int WINDOW_DEPTH  = pgb_pkg::DEF_WINDOW_DEPTH,
    parameter int DISTANCE_BITS = pgb_pkg::DEF_DISTANCE_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load,
    input  logic [DISTANCE_BITS-1:0] distance,
    input  logic                     no_echo,
    input  pgb_pkg::cfg_t            cfg,
    output logic                     sample_valid,
    output logic [pgb_pkg::sum_width(WINDOW_DEPTH, DISTANCE_BITS)-1:0] window_sum,
    output logic                     gesture_active
);
    import pgb_pkg::*;

    localparam int SUM_W = sum_width(WINDOW_DEPTH, DISTANCE_BITS);
    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int CMP_W = (DISTANCE_BITS > 12) ? DISTANCE_BITS : 12;

    logic [DISTANCE_BITS-1:0] win_reg [WINDOW_DEPTH];
    logic [DISTANCE_BITS-1:0] win_next [WINDOW_DEPTH];
    logic [PTR_W-1:0]         ptr_reg, ptr_next, ptr_wrap;
    logic [SUM_W-1:0]         sum_reg, sum_next, push_sum, fill_sum;
    logic                     active_reg, active_next;
    logic [7:0]               idle_reg, idle_next, idle_inc;
    logic                     valid_reg, valid;
    logic                     fill_en, push_en;
    logic [DISTANCE_BITS-1:0] fill_val;

    assign valid    = !no_echo && (CMP_W'(distance) < CMP_W'(cfg.range_limit));
    assign idle_inc = (idle_reg != IDLE_MAX) ? idle_reg + 8'd1 : idle_reg;
    assign ptr_wrap = (ptr_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + PTR_W'(1);
    assign push_sum = sum_reg - SUM_W'(win_reg[ptr_reg]) + SUM_W'(distance);
    assign fill_sum = SUM_W'(fill_val) * SUM_W'(WINDOW_DEPTH);

    always_comb begin
        active_next = active_reg;
        idle_next   = idle_reg;
        fill_en     = 1'b0;
        push_en     = 1'b0;
        fill_val    = '0;
        if (valid) begin
            idle_next   = '0;
            active_next = 1'b1;
            if (active_reg) begin
                push_en = 1'b1;
            end else begin
                // first good sample after idle floods the window
                fill_en  = 1'b1;
                fill_val = distance;
            end
        end else if (active_reg) begin
            idle_next = idle_inc;
            if (idle_inc >= cfg.idle_threshold) begin
                fill_en     = 1'b1;
                active_next = 1'b0;
            end
        end
    end

    always_comb begin
        sum_next = sum_reg;
        ptr_next = ptr_reg;
        if (fill_en) begin
            sum_next = fill_sum;
            ptr_next = '0;
        end else if (push_en) begin
            sum_next = push_sum;
            ptr_next = ptr_wrap;
        end
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            win_next[i] = win_reg[i];
            if (fill_en) begin
                win_next[i] = fill_val;
            end else if (push_en && (ptr_reg == PTR_W'(i))) begin
                win_next[i] = distance;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg    <= '0;
            ptr_reg    <= '0;
            active_reg <= 1'b0;
            idle_reg   <= '0;
            valid_reg  <= 1'b0;
        end else if (load) begin
            sum_reg    <= sum_next;
            ptr_reg    <= ptr_next;
            active_reg <= active_next;
            idle_reg   <= idle_next;
            valid_reg  <= valid;
        end
    end

    // window is always flooded before it is read, so no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    assign sample_valid   = valid_reg;
    assign window_sum     = sum_reg;
    assign gesture_active = active_reg;

endmodule

// File: sv/pgb_mean.sv
// Window mean: sum divided by the window depth through a reciprocal multiply.
module pgb_mean #(
    parameter int WINDOW_DEPTH  = pgb_pkg::DEF_WINDOW_DEPTH,
    parameter int DISTANCE_BITS = pgb_pkg::DEF_DISTANCE_BITS
) (
    input  logic                     aclk,
    input  logic                     load,
    input  logic [pgb_pkg::sum_width(WINDOW_DEPTH, DISTANCE_BITS)-1:0] window_sum,
    input  logic                     sample_valid_in,
    output logic [DISTANCE_BITS-1:0] mean,
    output logic                     sample_valid
);
    import pgb_pkg::*;

    localparam int SUM_W   = sum_width(WINDOW_DEPTH, DISTANCE_BITS);
    localparam int SH      = SUM_W + $clog2(WINDOW_DEPTH);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SH + DISTANCE_BITS;
    // ceil(2^SH / depth): exact quotient for every sum below 2^SUM_W
    localparam logic [63:0] RECIP =
        ((64'd1 << SH) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);

    logic [PROD_W-1:0]        prod;
    logic [DISTANCE_BITS-1:0] mean_reg, mean_next;
    logic                     valid_reg;

    assign prod      = PROD_W'(window_sum) * PROD_W'(RECIP[RECIP_W-1:0]);
    assign mean_next = prod[SH +: DISTANCE_BITS];

    always_ff @(posedge aclk) begin
        if (load) begin
            mean_reg  <= mean_next;
            valid_reg <= sample_valid_in;
        end
    end

    assign mean         = mean_reg;
    assign sample_valid = valid_reg;

endmodule

// File: sv/pgb_press.sv
// Gesture classification with hysteresis, press state machine and result register.
module pgb_press #(
    parameter int DISTANCE_BITS = pgb_pkg::DEF_DISTANCE_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  logic [DISTANCE_BITS-1:0]  mean,
    input  logic                      sample_valid_in,
    input  pgb_pkg::cfg_t             cfg,
    output logic                      sample_valid,
    output logic [pgb_pkg::MEAN_W-1:0] mean_distance,
    output pgb_pkg::gesture_kind_t    gesture,
    output pgb_pkg::press_state_t     press_state,
    output logic                      state_changed,
    output logic                      short_only_press,
    output logic                      long_only_press
);
    import pgb_pkg::*;

    localparam int CMP_W  = (DISTANCE_BITS + 1 > 14) ? DISTANCE_BITS + 1 : 14;
    localparam int MEXT_W = (DISTANCE_BITS > MEAN_W) ? DISTANCE_BITS : MEAN_W;

    logic signed [CMP_W-1:0] m_s, lo_s, hi_s;
    logic [MEXT_W-1:0]       mean_ext;
    gesture_kind_t           gest;
    logic [9:0]              hyst_reg, hyst_next;
    press_state_t            state_reg, state_next;
    // newest four entries; the fifth only matters right after a shift
    press_state_t            hist_reg [HIST_DEPTH-1];
    press_state_t            hist_next [HIST_DEPTH-1];
    press_state_t            hist_shift [HIST_DEPTH];
    logic                    changed, short_only, long_only;

    logic                    valid_reg;
    logic [MEAN_W-1:0]       mean_reg;
    gesture_kind_t           gest_reg;
    logic                    changed_reg, short_only_reg, long_only_reg;

    assign m_s      = $signed(CMP_W'(mean));
    assign lo_s     = $signed(CMP_W'(cfg.short_limit)) - $signed(CMP_W'(hyst_reg));
    assign hi_s     = $signed(CMP_W'(cfg.long_limit)) + $signed(CMP_W'(hyst_reg));
    assign mean_ext = MEXT_W'(mean);

    // a mean exactly on the lower limit belongs to no band
    always_comb begin
        if ((m_s != '0) && (m_s < lo_s)) begin
            gest      = G_SHORT;
            hyst_next = '0;
        end else if ((lo_s < m_s) && (m_s < hi_s)) begin
            gest      = G_LONG;
            hyst_next = cfg.hysteresis_step;
        end else begin
            gest      = G_NONE;
            hyst_next = '0;
        end
    end

    always_comb begin
        case (state_reg)
            PS_REL: begin
                if (gest == G_SHORT) begin
                    state_next = PS_REL_SHORT;
                end else if (gest == G_LONG) begin
                    state_next = PS_REL_LONG;
                end else begin
                    state_next = PS_REL;
                end
            end
            PS_REL_SHORT:  state_next = PS_SHORT;
            PS_REL_LONG:   state_next = PS_LONG;
            PS_SHORT: begin
                if (gest == G_LONG) begin
                    state_next = PS_SHORT_LONG;
                end else if (gest == G_NONE) begin
                    state_next = PS_SHORT_REL;
                end else begin
                    state_next = PS_SHORT;
                end
            end
            PS_SHORT_LONG: state_next = PS_LONG;
            PS_SHORT_REL:  state_next = PS_REL;
            PS_LONG_SHORT: state_next = PS_SHORT;
            PS_LONG: begin
                if (gest == G_SHORT) begin
                    state_next = PS_LONG_SHORT;
                end else if (gest == G_NONE) begin
                    state_next = PS_LONG_REL;
                end else begin
                    state_next = PS_LONG;
                end
            end
            PS_LONG_REL:   state_next = PS_REL;
            default:       state_next = PS_REL;
        endcase
    end

    always_comb begin
        changed       = (state_next != state_reg);
        hist_shift[0] = state_next;
        for (int i = 1; i < HIST_DEPTH; i++) begin
            hist_shift[i] = hist_reg[i-1];
        end
        for (int i = 0; i < HIST_DEPTH - 1; i++) begin
            hist_next[i] = changed ? hist_shift[i] : hist_reg[i];
        end
        short_only = changed && (hist_shift[4] == PS_REL) &&
                     (hist_shift[2] == PS_SHORT) && (hist_shift[0] == PS_REL);
        long_only  = changed && (hist_shift[4] == PS_REL) &&
                     (hist_shift[2] == PS_LONG) && (hist_shift[0] == PS_REL);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PS_REL;
            hyst_reg  <= '0;
            for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                hist_reg[i] <= PS_REL;
            end
        end else if (load) begin
            state_reg <= state_next;
            hyst_reg  <= hyst_next;
            for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                hist_reg[i] <= hist_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            valid_reg      <= sample_valid_in;
            mean_reg       <= mean_ext[MEAN_W-1:0];
            gest_reg       <= gest;
            changed_reg    <= changed;
            short_only_reg <= short_only;
            long_only_reg  <= long_only;
        end
    end

    assign sample_valid     = valid_reg;
    assign mean_distance    = mean_reg;
    assign gesture          = gest_reg;
    assign press_state      = state_reg;
    assign state_changed    = changed_reg;
    assign short_only_press = short_only_reg;
    assign long_only_press  = long_only_reg;

endmodule

// File: sv/proximity_gesture_button.sv
// Proximity gesture button: three-stage pipeline from range sample to press result.
//
// s_ channel takes one range sample per item (distance, no-echo flag in s_tuser).
// m_ channel returns one result per item: window mean, gesture class, press state
// and the short-only / long-only press flags; s_tuser-style flag m_tuser marks a
// sample that was in range.
// Pipeline: stage 1 qualifies the sample and updates the window and running sum,
// stage 2 divides the sum by the window depth (reciprocal multiply), stage 3
// classifies with hysteresis, steps the press machine and holds the result.
// m_tvalid rises once the item has passed the window, mean and press registers;
// throughput is one item per cycle while the receiver keeps m_tready high, set by
// the window-sum and press-state update loops, each closed through one register.
// When the receiver stalls, the result holds in stage 3 and the earlier stages keep
// filling; s_tready drops only when all three stages hold items.
// Reset (aresetn low, synchronous) empties the pipeline, zeroes the sum, idle
// count and hysteresis, sets the press machine to released and restores the
// register defaults. The APB port writes and reads the five limits; write them
// only while no item is in flight.
module proximity_gesture_button #(
    parameter int WINDOW_DEPTH  = pgb_pkg::DEF_WINDOW_DEPTH,
    parameter int DISTANCE_BITS = pgb_pkg::DEF_DISTANCE_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // [DISTANCE_BITS-1:0] distance, zero padded to whole bytes
    input  logic [((DISTANCE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // [0] no_echo
    input  logic                            s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [11:0] mean_distance, [13:12] gesture, [17:14] press_state,
    // [18] state_changed, [19] short_only_press, [20] long_only_press
    output logic [pgb_pkg::M_DATA_W-1:0]    m_tdata,
    // [0] sample_valid
    output logic                            m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pgb_pkg::ADDR_W-1:0]      paddr,
    input  logic [pgb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pgb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import pgb_pkg::*;

    localparam int SUM_W = sum_width(WINDOW_DEPTH, DISTANCE_BITS);

    cfg_t                     cfg_reg;
    logic                     cfg_wr;
    logic [2:0]               reg_idx;

    logic                     a_valid_reg, b_valid_reg, c_valid_reg;
    logic                     a_load, b_load, c_load;
    logic                     b_ready, c_ready;

    logic                     win_sample_valid, win_active;
    logic [SUM_W-1:0]         win_sum;
    logic [DISTANCE_BITS-1:0] mean;
    logic                     mean_sample_valid;

    logic                     out_valid;
    logic [MEAN_W-1:0]        out_mean;
    gesture_kind_t            out_gesture;
    press_state_t             out_press;
    logic                     out_changed, out_short_only, out_long_only;

    // ---------------- configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_limit     <= SHORT_LIMIT_RST;
            cfg_reg.long_limit      <= LONG_LIMIT_RST;
            cfg_reg.hysteresis_step <= HYSTERESIS_STEP_RST;
            cfg_reg.idle_threshold  <= IDLE_THRESHOLD_RST;
            cfg_reg.range_limit     <= RANGE_LIMIT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_SHORT_LIMIT:     cfg_reg.short_limit     <= pwdata[11:0];
                REG_LONG_LIMIT:      cfg_reg.long_limit      <= pwdata[11:0];
                REG_HYSTERESIS_STEP: cfg_reg.hysteresis_step <= pwdata[9:0];
                REG_IDLE_THRESHOLD:  cfg_reg.idle_threshold  <= pwdata[7:0];
                REG_RANGE_LIMIT:     cfg_reg.range_limit     <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SHORT_LIMIT:     prdata = APB_DATA_W'(cfg_reg.short_limit);
            REG_LONG_LIMIT:      prdata = APB_DATA_W'(cfg_reg.long_limit);
            REG_HYSTERESIS_STEP: prdata = APB_DATA_W'(cfg_reg.hysteresis_step);
            REG_IDLE_THRESHOLD:  prdata = APB_DATA_W'(cfg_reg.idle_threshold);
            REG_RANGE_LIMIT:     prdata = APB_DATA_W'(cfg_reg.range_limit);
            default:             prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control, bubbles collapse
    assign c_ready  = !c_valid_reg || m_tready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign s_tready = !a_valid_reg || b_ready;
    assign a_load   = s_tvalid && s_tready;
    assign b_load   = a_valid_reg && b_ready;
    assign c_load   = b_valid_reg && c_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                a_valid_reg <= s_tvalid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // ---------------- stages
    pgb_window #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_window (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (a_load),
        .distance       (s_tdata[DISTANCE_BITS-1:0]),
        .no_echo        (s_tuser),
        .cfg            (cfg_reg),
        .sample_valid   (win_sample_valid),
        .window_sum     (win_sum),
        .gesture_active (win_active)
    );

    pgb_mean #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_mean (
        .aclk            (aclk),
        .load            (b_load),
        .window_sum      (win_sum),
        .sample_valid_in (win_sample_valid),
        .mean            (mean),
        .sample_valid    (mean_sample_valid)
    );

    pgb_press #(
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_press (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (c_load),
        .mean             (mean),
        .sample_valid_in  (mean_sample_valid),
        .cfg              (cfg_reg),
        .sample_valid     (out_valid),
        .mean_distance    (out_mean),
        .gesture          (out_gesture),
        .press_state      (out_press),
        .state_changed    (out_changed),
        .short_only_press (out_short_only),
        .long_only_press  (out_long_only)
    );

    assign m_tvalid = c_valid_reg;
    assign m_tuser  = out_valid;
    assign m_tdata  = {3'b000, out_long_only, out_short_only, out_changed,
                       out_press, out_gesture, out_mean};

`ifndef SYNTH
    // an idle window is always flushed to zero
    a_idle_sum_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !win_active |-> (win_sum == '0))
        else $error("window sum nonzero while no gesture is active");

    a_short_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (c_valid_reg && out_short_only) |->
            (out_changed && (out_press == PS_REL) && !out_long_only))
        else $error("short-only press flagged outside a change to released");

    a_long_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (c_valid_reg && out_long_only) |-> (out_changed && (out_press == PS_REL)))
        else $error("long-only press flagged outside a change to released");
`endif

endmodule
